@@ design/smpd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the button table of the serial mouse packet decoder.
package smpd_pkg;

  localparam int NUM_BUTTONS = 3;

  localparam logic [2:0] BTN_MASK   = 3'((1 << NUM_BUTTONS) - 1);
  localparam logic [7:0] SYNC_MASK  = 8'hF8;
  localparam logic [7:0] SYNC_VALUE = 8'h80;
  localparam logic [2:0] POS_HUNT   = 3'd0;
  localparam logic [2:0] POS_LAST   = 3'd4;
  localparam int         MOTION_BIT = 3;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_MOTION  = 2'd2
  } smpd_kind_t;

  // Decoded packet: pending event mask (buttons in bits 0..2, motion in bit 3),
  // the new button word and the motion sums.
  typedef struct packed {
    logic [3:0]        rem;
    logic [2:0]        want;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
  } smpd_pkt_t;

  function automatic logic [2:0] button_map(input logic [2:0] code);
    logic [2:0] res;
    unique case (code)
      3'd0: res = 3'd0;
      3'd1: res = 3'd4;
      3'd2: res = 3'd1;
      3'd3: res = 3'd5;
      3'd4: res = 3'd2;
      3'd5: res = 3'd6;
      3'd6: res = 3'd3;
      3'd7: res = 3'd7;
      default: res = 3'd0;
    endcase
    return res;
  endfunction

endpackage

@@ design/serial_mouse_packet_decoder.sv @@
`timescale 1ns / 1ps
// Top level of the five-byte serial mouse packet decoder.
//
// Received bytes enter on the in_ channel, one transaction per cycle. While
// hunting, a byte whose top five bits are 10000 starts a packet and any other
// byte is dropped; the next four bytes (X1, Y1, X2, Y2) are taken as data.
// The fifth byte is decoded in the cycle it is accepted: every button whose
// state changed gives a press or release event (button 0 first), then a
// motion event with the signed sums X1+X2 and Y1+Y2 follows if either is
// nonzero. Events leave one per cycle while out_stall is low, through the
// out_ channel from a single event register, out_last marking the final event
// of a packet. Bytes that do not close a packet are always taken at once; a
// closing byte is held off (in_stall) only while the previous packet still
// has events waiting, and a packet gives up to four events. While cfg enable
// is 0, bytes are accepted and ignored, and a packet in progress resumes when
// enable returns to 1.
module serial_mouse_packet_decoder import smpd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_event_kind,
  output logic [1:0]        out_button_index,
  output logic signed [8:0] out_delta_x,
  output logic signed [8:0] out_delta_y,
  output logic              out_last
);

  logic       enable_r;
  logic [2:0] pos_r, pos_nxt;
  logic [2:0] held_r, held_nxt;
  logic [7:0] sync_r;
  logic [7:0] x1_r, y1_r, x2_r;

  logic       in_acc;
  logic       active;
  logic       closing;
  logic       load;
  logic       q_free;
  logic       is_sync;
  logic [2:0] want;
  smpd_pkt_t  pkt;

  // Configuration: single enable bit, to be written only while idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_we) begin
      enable_r <= cfg_wdata;
    end
  end

  // Hold the closing byte off while the event register cannot take a packet.
  assign closing  = enable_r && (pos_r == POS_LAST);
  assign in_stall = closing && !q_free;
  assign in_acc   = in_valid && !in_stall;
  assign active   = in_acc && enable_r;
  assign load     = active && (pos_r == POS_LAST);
  assign is_sync  = ((in_rx_byte & SYNC_MASK) == SYNC_VALUE);

  // Byte position: hunt for sync, then count four data bytes.
  always_comb begin
    pos_nxt = pos_r;
    if (active) begin
      priority if (pos_r == POS_HUNT) begin
        pos_nxt = is_sync ? 3'd1 : POS_HUNT;
      end else if (pos_r < POS_LAST) begin
        pos_nxt = pos_r + 3'd1;
      end else begin
        pos_nxt = POS_HUNT;
      end
    end
  end

  // Decode: button word from the inverted low bits of the sync byte,
  // motion from the signed byte sums (the last Y byte comes straight in).
  assign want     = button_map(~sync_r[2:0]) & BTN_MASK;
  assign held_nxt = load ? want : held_r;

  always_comb begin
    pkt.want = want;
    pkt.dx   = $signed({x1_r[7], x1_r}) + $signed({x2_r[7], x2_r});
    pkt.dy   = $signed({y1_r[7], y1_r}) + $signed({in_rx_byte[7], in_rx_byte});
    pkt.rem  = {(pkt.dx != 9'sd0) || (pkt.dy != 9'sd0), want ^ held_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_HUNT;
      held_r <= 3'd0;
    end else begin
      pos_r  <= pos_nxt;
      held_r <= held_nxt;
    end
  end

  // Packet bytes: stored as they arrive, no reset needed.
  always_ff @(posedge clk) begin
    if (active) begin
      unique case (pos_r)
        3'd0: begin
          if (is_sync) sync_r <= in_rx_byte;
        end
        3'd1: x1_r <= in_rx_byte;
        3'd2: y1_r <= in_rx_byte;
        3'd3: x2_r <= in_rx_byte;
        default: ;
      endcase
    end
  end

  smpd_evq u_evq (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (load),
    .pkt              (pkt),
    .free             (q_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_button_index (out_button_index),
    .out_delta_x      (out_delta_x),
    .out_delta_y      (out_delta_y),
    .out_last         (out_last)
  );

  // Buttons beyond NUM_BUTTONS never become held.
  a_held_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r & ~BTN_MASK) == 3'd0)
    else $error("held button outside the configured button count");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("byte position out of range");

  // A stalled input always means a packet still draining.
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && closing))
    else $error("input stalled with no pending events");

  // A decoded packet with any event shows up on the output next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (pkt.rem != 4'd0)) |=> out_valid)
    else $error("decoded events not presented");

  // After a closing byte is decoded, the byte position returns to hunting.
  a_load_pos: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (pos_r == POS_HUNT))
    else $error("packet decode did not return to hunting");

endmodule

@@ design/smpd_evq.sv @@
`timescale 1ns / 1ps
// Event register of the decoder: holds one decoded packet and drains its events in order.
module smpd_evq import smpd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  smpd_pkt_t         pkt,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_event_kind,
  output logic [1:0]        out_button_index,
  output logic signed [8:0] out_delta_x,
  output logic signed [8:0] out_delta_y,
  output logic              out_last
);

  logic [3:0]        rem_r, rem_nxt;
  logic [2:0]        want_r;
  logic signed [8:0] dx_r, dy_r;
  logic [3:0]        cur;
  logic [3:0]        rest;
  logic              out_acc;
  smpd_kind_t        kind;
  logic [1:0]        idx;

  assign out_valid = |rem_r;
  assign cur       = rem_r & (~rem_r + 4'd1);
  assign rest      = rem_r & ~cur;
  assign out_last  = (rest == 4'd0);
  assign out_acc   = out_valid && !out_stall;
  assign free      = !out_valid || (out_acc && out_last);

  always_comb begin
    kind = KIND_MOTION;
    idx  = 2'd0;
    priority if (cur[0]) begin
      kind = want_r[0] ? KIND_PRESS : KIND_RELEASE;
      idx  = 2'd0;
    end else if (cur[1]) begin
      kind = want_r[1] ? KIND_PRESS : KIND_RELEASE;
      idx  = 2'd1;
    end else if (cur[2]) begin
      kind = want_r[2] ? KIND_PRESS : KIND_RELEASE;
      idx  = 2'd2;
    end else begin
      kind = KIND_MOTION;
      idx  = 2'd0;
    end
  end

  assign out_event_kind   = kind;
  assign out_button_index = idx;
  assign out_delta_x      = cur[MOTION_BIT] ? dx_r : 9'sd0;
  assign out_delta_y      = cur[MOTION_BIT] ? dy_r : 9'sd0;

  always_comb begin
    rem_nxt = rem_r;
    priority if (load) begin
      rem_nxt = pkt.rem;
    end else if (out_acc) begin
      rem_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 4'd0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      want_r <= pkt.want;
      dx_r   <= pkt.dx;
      dy_r   <= pkt.dy;
    end
  end

endmodule

@@ sim/serial_mouse_packet_decoder_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the five-byte serial mouse packet decoder.
module serial_mouse_packet_decoder_tb;
  import smpd_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RESET_LEN   = 11;
  localparam int SETTLE      = 8;     // decode is same-cycle
  localparam int STALL_LIMIT = 2000;  // cycles without any transaction
  localparam int PHASE_ITEMS = 106;
  localparam int SHOW_MAX    = 10;

  // Inverted sync bits select a button word from this fixed permutation.
  localparam logic [2:0] BTN_TABLE [0:7] = '{3'd0, 3'd4, 3'd1, 3'd5,
                                             3'd2, 3'd6, 3'd3, 3'd7};

  typedef struct {
    logic [7:0] rx;
    bit         drain_first;  // hold this byte back until all events are out
  } rx_item_t;

  typedef struct {
    smpd_kind_t        kind;
    logic [1:0]        btn;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic              last;
  } mouse_event_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic              cfg_wdata  = 1'b0;
  logic              in_valid   = 1'b0;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              out_stall  = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [1:0]        out_event_kind;
  logic [1:0]        out_button_index;
  logic signed [8:0] out_delta_x;
  logic signed [8:0] out_delta_y;
  logic              out_last;

  serial_mouse_packet_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_button_index (out_button_index),
    .out_delta_x      (out_delta_x),
    .out_delta_y      (out_delta_y),
    .out_last         (out_last)
  );

  always #(CLK_HALF) clk = ~clk;

  // Bytes still to be sent, and the events predicted for bytes already taken.
  rx_item_t     rx_pending[$];
  mouse_event_t event_q[$];

  // Shadow copy of the decoder: enable register, hunt position, packet store, held buttons.
  logic       mdl_enable = 1'b0;
  logic [2:0] mdl_pos    = POS_HUNT;
  logic [7:0] mdl_sync   = 8'h00;
  logic [7:0] mdl_data [0:3];
  logic [2:0] mdl_held   = 3'b000;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int owed_events   = 0;   // event_q depth as of the previous edge
  int quiet_cycles  = 0;
  int mismatches    = 0;
  int bytes_taken   = 0;
  int packets_done  = 0;
  int events_seen   = 0;
  rx_item_t nxt_item;

  // Advance the shadow decoder by one received byte and queue what it emits.
  task automatic decode_rx_byte(input logic [7:0] b);
    mouse_event_t      evs[$];
    mouse_event_t      ev;
    logic [2:0]        code;
    logic [2:0]        want;
    logic signed [8:0] sx;
    logic signed [8:0] sy;
    if (!mdl_enable) return;
    if (mdl_pos == POS_HUNT || mdl_pos > POS_LAST) begin
      // Hunting: only a sync byte starts a packet, everything else is dropped.
      if ((b & SYNC_MASK) == SYNC_VALUE) begin
        mdl_sync = b;
        mdl_pos  = 3'd1;
      end else begin
        mdl_pos = POS_HUNT;
      end
      return;
    end
    // Inside a packet every byte is data, even one that looks like sync.
    mdl_data[2'(mdl_pos - 3'd1)] = b;
    if (mdl_pos < POS_LAST) begin
      mdl_pos = mdl_pos + 3'd1;
      return;
    end
    mdl_pos = POS_HUNT;
    packets_done++;
    code = ~mdl_sync[2:0];
    want = BTN_TABLE[code];
    for (int j = 0; j < NUM_BUTTONS; j++) begin
      if (mdl_held[j] != want[j]) begin
        ev.kind = mdl_held[j] ? KIND_RELEASE : KIND_PRESS;
        ev.btn  = 2'(j);
        ev.dx   = '0;
        ev.dy   = '0;
        ev.last = 1'b0;
        evs.push_back(ev);
        mdl_held[j] = want[j];
      end
    end
    sx = $signed({mdl_data[0][7], mdl_data[0]}) + $signed({mdl_data[2][7], mdl_data[2]});
    sy = $signed({mdl_data[1][7], mdl_data[1]}) + $signed({mdl_data[3][7], mdl_data[3]});
    if (sx != 0 || sy != 0) begin
      ev.kind = KIND_MOTION;
      ev.btn  = 2'd0;
      ev.dx   = sx;
      ev.dy   = sy;
      ev.last = 1'b0;
      evs.push_back(ev);
    end
    // Flag the final event of this packet, then hand them all to the checker.
    if (evs.size() != 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) event_q.push_back(evs[i]);
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= SHOW_MAX) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Driver: present the next byte once the current one is taken or none is up.
  // A byte marked drain_first waits until no byte is in flight and the decoder
  // has emptied its events.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_rx_byte <= 8'h00;
    end else if (!in_valid || !in_stall) begin
      if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          (!rx_pending[0].drain_first ||
           (!in_valid && owed_events == 0 && !out_valid))) begin
        nxt_item = rx_pending.pop_front();
        in_valid   <= 1'b1;
        in_rx_byte <= nxt_item.rx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on every accepted byte, check every accepted event
  // against the oldest prediction, and drive the random receiver stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        bytes_taken++;
        decode_rx_byte(in_rx_byte);
      end
      if (out_valid && !out_stall) begin
        events_seen++;
        if (event_q.size() == 0) begin
          report_mismatch($sformatf("unexpected event kind=%0d btn=%0d dx=%0d dy=%0d last=%0b",
                                    out_event_kind, out_button_index, out_delta_x,
                                    out_delta_y, out_last));
        end else begin
          mouse_event_t exp_ev;
          exp_ev = event_q.pop_front();
          if (out_event_kind !== exp_ev.kind || out_button_index !== exp_ev.btn ||
              out_delta_x !== exp_ev.dx || out_delta_y !== exp_ev.dy ||
              out_last !== exp_ev.last) begin
            report_mismatch($sformatf(
              "exp kind=%0d btn=%0d dx=%0d dy=%0d last=%0b, got kind=%0d btn=%0d dx=%0d dy=%0d last=%0b",
              exp_ev.kind, exp_ev.btn, exp_ev.dx, exp_ev.dy, exp_ev.last,
              out_event_kind, out_button_index, out_delta_x, out_delta_y, out_last));
          end
        end
      end
      out_stall   <= ($urandom_range(99) < recv_idle_pct);
      owed_events <= event_q.size();
    end
  end

  // Count cycles in which no transaction of any kind happens.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Watchdog: end the run if the handshakes stop moving.
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input bit drain_first = 1'b0);
    rx_item_t it;
    it.rx          = b;
    it.drain_first = drain_first;
    rx_pending.push_back(it);
  endtask

  task automatic push_packet(input logic [2:0] btn_bits, input logic [7:0] x1,
                             input logic [7:0] y1, input logic [7:0] x2,
                             input logic [7:0] y2, input bit drain_first = 1'b0);
    push_byte(SYNC_VALUE | {5'd0, btn_bits}, drain_first);
    push_byte(x1);
    push_byte(y1);
    push_byte(x2);
    push_byte(y2);
  endtask

  // Hold until every byte is taken and every event is out, then let the
  // decoder settle. Observe at the falling edge so nothing races the driver.
  task automatic wait_quiet();
    @(negedge clk);
    while (rx_pending.size() != 0 || in_valid || event_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_enable(input logic value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    mdl_enable = value;
  endtask

  // Random data byte: mostly anything, sometimes a byte with the sync pattern.
  function automatic logic [7:0] rand_data();
    if ($urandom_range(7) == 0) return SYNC_VALUE | 8'($urandom_range(7));
    return 8'($urandom_range(255));
  endfunction

  // Mostly well-formed packets with random content; some cancel their motion
  // to zero, and loose noise bytes knock the stream out of alignment.
  task automatic push_random_stream(input int n_items);
    int         sent;
    logic [7:0] x1, y1, x2, y2;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        push_byte(8'($urandom_range(255)));
        sent += 1;
      end else begin
        x1 = rand_data();
        y1 = rand_data();
        if ($urandom_range(4) == 0) begin
          x2 = 8'(-x1);
          y2 = 8'(-y1);
        end else begin
          x2 = rand_data();
          y2 = rand_data();
        end
        push_packet(3'($urandom_range(7)), x1, y1, x2, y2, $urandom_range(19) == 0);
        sent += 5;
      end
    end
  endtask

  initial begin
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Out of reset the decoder is disabled: a full packet must leave no trace.
    push_packet(3'd0, 8'h7F, 8'h7F, 8'h7F, 8'h7F);
    wait_quiet();
    write_enable(1'b1);

    // Drop non-sync bytes while hunting, including one with a near-miss top.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h88);
    // No button change and zero motion: the packet produces nothing.
    push_packet(3'd7, 8'h00, 8'h00, 8'h00, 8'h00);
    // All three buttons pressed plus the largest motion; wait for a clean
    // output side first so the four events leave back to back.
    push_packet(3'd0, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b1);
    // Same buttons, most negative motion: a lone motion event.
    push_packet(3'd0, 8'h80, 8'h80, 8'h80, 8'h80);
    // Release everything; X cancels, Y carries a data byte that looks like sync.
    push_packet(3'd7, 8'h01, 8'h85, 8'hFF, 8'h00);
    // Start a packet, then disable in the middle of it.
    push_byte(8'h82);
    push_byte(8'h10);
    push_byte(8'h20);
    wait_quiet();
    write_enable(1'b0);
    push_byte(8'h00);
    push_byte(8'h81);
    push_byte(8'hFF);
    wait_quiet();
    // Resume: the two remaining data bytes close the interrupted packet.
    write_enable(1'b1);
    push_byte(8'hF0);
    push_byte(8'hE0);
    wait_quiet();

    // Random part under three stall profiles, toggling enable mid-phase.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 65 : 0;
      recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 8 : 0;
      write_enable(1'b1);
      push_random_stream(PHASE_ITEMS / 2);
      wait_quiet();
      write_enable(1'b0);
      for (int k = 0; k < 6; k++) push_byte(8'($urandom_range(255)));
      wait_quiet();
      write_enable(1'b1);
      push_random_stream(PHASE_ITEMS - PHASE_ITEMS / 2);
      wait_quiet();
    end

    $display("Run covered %0d received bytes and %0d decoded packets, %0d events checked,",
             bytes_taken, packets_done, events_seen);
    $display("over three stall profiles with enable toggled inside and between packets.");
    if (mismatches == 0 && event_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d events never arrived", mismatches, event_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/smpd_pkg.sv
design/smpd_evq.sv
design/serial_mouse_packet_decoder.sv
sim/serial_mouse_packet_decoder_tb.sv
